// ===== hw/rtl/pip_pkg.sv =====
`default_nettype none

package pip_pkg;

    // polygon store and coordinate sizes
    localparam int MAX_VERTS  = 64;
    localparam int MIN_VERTS  = 3;
    localparam int COORD_BITS = 16;

    // field widths fixed by the request format
    localparam int VIDX_W = 6;
    localparam int CFG_W  = 7;

    // derived widths
    localparam int ADDR_W = $clog2(MAX_VERTS);
    localparam int CNT_W  = $clog2(MAX_VERTS + 1);
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;

    // request kinds
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TEST = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // tags that travel with a vertex read
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } rd_tag_t;

    // status from the edge pipeline
    typedef struct packed {
        logic done;
        logic in_poly;
    } edge_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pip_if.sv =====
`default_nettype none

// request channel: vertex load or point test
interface pip_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 req_type;
    logic [pip_pkg::VIDX_W-1:0]           vertex_index;
    logic signed [pip_pkg::COORD_BITS-1:0] coord_x;
    logic signed [pip_pkg::COORD_BITS-1:0] coord_y;

    modport source (output valid, req_type, vertex_index, coord_x, coord_y, input ready);
    modport sink   (input valid, req_type, vertex_index, coord_x, coord_y, output ready);
endinterface

// result channel: inside flag of a point test
interface pip_res_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (output valid, inside_res, input ready);
    modport sink   (input valid, inside_res, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/point_in_polygon_test_unit.sv =====
`default_nettype none

// point in polygon test by crossing-number parity
//
// req channel carries one transaction per item: req_type load writes the
// vertex (coord_x, coord_y) into slot vertex_index and gives no result;
// req_type test walks every edge of the first vertex_count vertices and
// returns one transaction on res with inside_res set for an odd crossing count.
// cfg_we / cfg_wdata write vertex_count (clamped to 3..64); write it only while
// the block is idle.
// a test for n vertices makes n + 1 reads of the single vertex memory read port,
// one vertex per cycle, then runs a three stage difference / multiply / compare
// pipeline; the finish state then hands the flag to the output register once
// that register is free or its result is being taken.
// the output register holds a result while res is stalled; loads and a new
// test are still taken, and a test that finishes meanwhile waits for the slot.
// reset clears the sequencer and the output valid and sets vertex_count to 3;
// vertex memory is not cleared, every slot used by a test must be loaded first.
module point_in_polygon_test_unit (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [pip_pkg::CFG_W-1:0] cfg_wdata,
    pip_req_if.sink                        req,
    pip_res_if.source                      res
);
    import pip_pkg::*;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]        cfg_count_reg;
    logic [CNT_W-1:0]        n_clamp;
    logic [CNT_W-1:0]        n_reg;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [CNT_W-1:0]        addr_full;
    logic [ADDR_W-1:0]       raddr;
    logic signed [COORD_BITS-1:0] tx_reg, ty_reg;
    logic signed [COORD_BITS-1:0] rx, ry;
    rd_tag_t                 tag_reg, tag_next;
    edge_stat_t              est;
    logic                    req_ready;
    logic                    mem_we;
    logic                    clr;
    logic                    start;
    logic                    issue;
    logic                    load_res;
    logic                    res_valid_reg, res_valid_next;
    logic                    inside_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_count_reg <= CFG_W'(MIN_VERTS);
        end
        else if (cfg_we)
        begin
            cfg_count_reg <= cfg_wdata;
        end
    end

    // clamp vertex count to the supported range
    always_comb
    begin
        if (int'(cfg_count_reg) < MIN_VERTS)
        begin
            n_clamp = CNT_W'(MIN_VERTS);
        end
        else if (int'(cfg_count_reg) > MAX_VERTS)
        begin
            n_clamp = CNT_W'(MAX_VERTS);
        end
        else
        begin
            n_clamp = CNT_W'(cfg_count_reg);
        end
    end

    // read order: last vertex first, then 0 .. n-1
    always_comb
    begin
        addr_full = (cnt_reg == '0) ? (n_reg - CNT_W'(1)) : (cnt_reg - CNT_W'(1));
        raddr     = addr_full[ADDR_W-1:0];
    end

    // sequencer next state and outputs
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        req_ready  = 1'b0;
        mem_we     = 1'b0;
        clr        = 1'b0;
        start      = 1'b0;
        issue      = 1'b0;
        load_res   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req.valid)
                begin
                    if (req.req_type == REQ_LOAD)
                    begin
                        mem_we = int'(req.vertex_index) < MAX_VERTS;
                    end
                    else
                    begin
                        clr        = 1'b1;
                        start      = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                issue    = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == n_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (est.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    load_res   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // read tags follow the memory latency
    always_comb
    begin
        tag_next.valid = issue;
        tag_next.first = issue && (cnt_reg == '0);
        tag_next.last  = issue && (cnt_reg == n_reg);
    end

    // output register
    always_comb
    begin
        if (load_res)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            tag_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            tag_reg       <= tag_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // test point, count and result payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            tx_reg <= req.coord_x;
            ty_reg <= req.coord_y;
            n_reg  <= n_clamp;
        end
        if (load_res)
        begin
            inside_reg <= est.in_poly;
        end
    end

    pip_vertex_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (ADDR_W'(req.vertex_index)),
        .wx    (req.coord_x),
        .wy    (req.coord_y),
        .raddr (raddr),
        .rx    (rx),
        .ry    (ry)
    );

    pip_edge_unit u_edge (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (clr),
        .tag   (tag_reg),
        .rx    (rx),
        .ry    (ry),
        .tx    (tx_reg),
        .ty    (ty_reg),
        .stat  (est)
    );

    assign req.ready      = req_ready;
    assign res.valid      = res_valid_reg;
    assign res.inside_res = inside_reg;

    // a result appears only after a finished walk
    a_res_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish");

    // the edge pipeline reports completion only while draining
    a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        est.done |-> (state_reg == ST_DRAIN))
        else $error("edge done outside drain");

    // the read counter never passes the vertex count
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (cnt_reg <= n_reg))
        else $error("read counter beyond vertex count");

    // no memory write during a walk
    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_IDLE) && !tag_reg.valid)
        else $error("vertex write while a test is running");

endmodule

`default_nettype wire

// ===== hw/rtl/pip_vertex_mem.sv =====
`default_nettype none

module pip_vertex_mem (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [pip_pkg::ADDR_W-1:0]           waddr,
    input  wire logic signed [pip_pkg::COORD_BITS-1:0] wx,
    input  wire logic signed [pip_pkg::COORD_BITS-1:0] wy,
    input  wire logic [pip_pkg::ADDR_W-1:0]           raddr,
    output logic signed [pip_pkg::COORD_BITS-1:0]      rx,
    output logic signed [pip_pkg::COORD_BITS-1:0]      ry
);
    import pip_pkg::*;

    logic signed [COORD_BITS-1:0] x_mem [MAX_VERTS];
    logic signed [COORD_BITS-1:0] y_mem [MAX_VERTS];

    // single write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            x_mem[waddr] <= wx;
            y_mem[waddr] <= wy;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rx <= x_mem[raddr];
        ry <= y_mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pip_edge_unit.sv =====
`default_nettype none

module pip_edge_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 clr,
    input  wire pip_pkg::rd_tag_t                     tag,
    input  wire logic signed [pip_pkg::COORD_BITS-1:0] rx,
    input  wire logic signed [pip_pkg::COORD_BITS-1:0] ry,
    input  wire logic signed [pip_pkg::COORD_BITS-1:0] tx,
    input  wire logic signed [pip_pkg::COORD_BITS-1:0] ty,
    output pip_pkg::edge_stat_t                       stat
);
    import pip_pkg::*;

    // previous vertex of the walk
    logic signed [COORD_BITS-1:0] prev_x_reg;
    logic signed [COORD_BITS-1:0] prev_y_reg;

    // stage 1: differences and straddle test
    logic                     s1_valid_reg, s1_valid_next;
    logic                     s1_last_reg, s1_last_next;
    logic                     s1_strad_reg, s1_strad_next;
    logic signed [DIFF_W-1:0] s1_d_reg, s1_d_next;
    logic signed [DIFF_W-1:0] s1_a_reg, s1_a_next;
    logic signed [DIFF_W-1:0] s1_b_reg, s1_b_next;
    logic signed [DIFF_W-1:0] s1_c_reg, s1_c_next;

    // stage 2: cross products
    logic                     s2_valid_reg, s2_valid_next;
    logic                     s2_last_reg, s2_last_next;
    logic                     s2_strad_reg, s2_strad_next;
    logic                     s2_dpos_reg, s2_dpos_next;
    logic signed [PROD_W-1:0] s2_lhs_reg, s2_lhs_next;
    logic signed [PROD_W-1:0] s2_rhs_reg, s2_rhs_next;

    // stage 3: parity and done
    logic parity_reg, parity_next;
    logic done_reg, done_next;
    logic hit;

    // edge (cur, prev) differences
    always_comb
    begin
        s1_valid_next = tag.valid && !tag.first;
        s1_last_next  = tag.last;
        s1_strad_next = (ry > ty) != (prev_y_reg > ty);
        s1_d_next     = {prev_y_reg[COORD_BITS-1], prev_y_reg} - {ry[COORD_BITS-1], ry};
        s1_a_next     = {tx[COORD_BITS-1], tx} - {rx[COORD_BITS-1], rx};
        s1_b_next     = {prev_x_reg[COORD_BITS-1], prev_x_reg} - {rx[COORD_BITS-1], rx};
        s1_c_next     = {ty[COORD_BITS-1], ty} - {ry[COORD_BITS-1], ry};
    end

    // exact products replace the crossing division
    always_comb
    begin
        s2_valid_next = s1_valid_reg;
        s2_last_next  = s1_last_reg;
        s2_strad_next = s1_strad_reg;
        s2_dpos_next  = !s1_d_reg[DIFF_W-1] && (s1_d_reg != '0);
        s2_lhs_next   = s1_a_reg * s1_d_reg;
        s2_rhs_next   = s1_b_reg * s1_c_reg;
    end

    // compare sense flips with the sign of the y difference
    always_comb
    begin
        hit         = s2_dpos_reg ? (s2_lhs_reg < s2_rhs_reg) : (s2_rhs_reg < s2_lhs_reg);
        parity_next = parity_reg;
        if (clr)
        begin
            parity_next = 1'b0;
        end
        else if (s2_valid_reg && s2_strad_reg && hit)
        begin
            parity_next = !parity_reg;
        end
        done_next = s2_valid_reg && s2_last_reg;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (tag.valid)
        begin
            prev_x_reg <= rx;
            prev_y_reg <= ry;
        end
        s1_last_reg  <= s1_last_next;
        s1_strad_reg <= s1_strad_next;
        s1_d_reg     <= s1_d_next;
        s1_a_reg     <= s1_a_next;
        s1_b_reg     <= s1_b_next;
        s1_c_reg     <= s1_c_next;
        s2_last_reg  <= s2_last_next;
        s2_strad_reg <= s2_strad_next;
        s2_dpos_reg  <= s2_dpos_next;
        s2_lhs_reg   <= s2_lhs_next;
        s2_rhs_reg   <= s2_rhs_next;
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            parity_reg   <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            parity_reg   <= parity_next;
            done_reg     <= done_next;
        end
    end

    assign stat.done    = done_reg;
    assign stat.in_poly = parity_reg;

endmodule

`default_nettype wire
